// ===== rtl/kal_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kal_pkg: shared types for the k-th ancestor lifting block
// Holds the transfer structs, command codes and controller states.
// ---------------------------------------------------------------------------
package kal_pkg;

  localparam int ID_W   = 12;
  localparam int MODE_W = 2;

  // command codes; the fourth code is ignored by the block
  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD  = 2'd0,
    MODE_BUILD = 2'd1,
    MODE_QUERY = 2'd2
  } kal_mode_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   node_id;
    logic [ID_W-1:0]   parent_id;
    logic [ID_W-1:0]   jump_count;
  } kal_in_t;

  typedef struct packed {
    logic [ID_W-1:0] ancestor_id;
    logic            found;
  } kal_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BUILD,
    ST_DRAIN,
    ST_QUERY
  } kal_state_t;

endpackage

// ===== rtl/kth_ancestor_lifting.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kth_ancestor_lifting: binary lifting k-th ancestor engine
// Parent table and jump table in on-chip memories, built level by level.
// ---------------------------------------------------------------------------
// Usage
//   A command is transferred when start is high and busy is low. Every
//   command gives exactly one result on out_item, shown for one cycle with
//   out_valid high; the receiver cannot stall, so it must take it then.
//   Load parent, ignored codes, and queries of an invalid node or of a jump
//   count at or beyond 2^LOG_LEVELS: result in the cycle after the transfer,
//   busy stays low, so one such command per cycle.
//   Ancestor query: busy while it climbs one table level per cycle through
//   the jump memory read port; the result is shown in the first cycle with
//   busy low again, so a new command can be taken while the result is shown.
//   Build: per level, all MAX_NODES nodes are issued, then the
//   read-read-write pipeline empties (read-write at level zero, which
//   copies the parent entry) before the next level starts; the result is
//   shown in the first cycle with busy low again.
//   Reset: the parent memory is cleared one entry per cycle, with busy high
//   until all MAX_NODES entries are cleared. The jump memory is not cleared;
//   it reads as none until the first build completes.
// ---------------------------------------------------------------------------
module kth_ancestor_lifting
  import kal_pkg::*;
#(
  parameter int MAX_NODES  = 4096,
  parameter int LOG_LEVELS = 12
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  kal_in_t  in_item,
  output logic     out_valid,
  output kal_out_t out_item
);

  localparam int NB     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int LBI    = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1;
  localparam int LB     = $clog2(LOG_LEVELS + 1);
  localparam int JAW    = LBI + NB;
  localparam int JDEPTH = LOG_LEVELS * (1 << NB);

  // controller state
  kal_state_t       state_r, state_nxt;
  logic [NB-1:0]    bn_r, bn_nxt;
  logic [LBI-1:0]   bl_r, bl_nxt;
  logic             built_r, built_nxt;

  // build pipeline
  logic             s1_vld_r, s1_vld_nxt;
  logic [LBI-1:0]   s1_lvl_r;
  logic [NB-1:0]    s1_node_r;
  logic             s2_vld_r, s2_vld_nxt;
  logic [LBI-1:0]   s2_lvl_r;
  logic [NB-1:0]    s2_node_r;

  // query walker
  logic [LB-1:0]    q_lvl_r, q_lvl_nxt;
  logic [ID_W-1:0]  q_cur_r, q_cur_nxt;
  logic             q_pend_r, q_pend_nxt;
  logic [ID_W-1:0]  q_cnt_r, q_cnt_nxt;
  logic [ID_W-1:0]  q_cur;

  // result register
  logic             out_valid_r, out_valid_nxt;
  kal_out_t         out_item_r, out_item_nxt;

  // memory ports
  logic             p_we;
  logic [NB-1:0]    p_wa, p_ra;
  logic [ID_W-1:0]  p_wd, prd_q;
  logic             j_we;
  logic [JAW-1:0]   j_wa, j_ra, j_rb;
  logic [ID_W-1:0]  j_wd, rda_q, rdb_q;

  logic [ID_W-1:0]  pmem [MAX_NODES];
  logic [ID_W-1:0]  jmem [JDEPTH];

  logic             accept;
  logic             node_ok;
  logic             par_ok;
  logic             cnt_sat;

  assign accept  = start && (state_r == ST_IDLE);
  assign node_ok = (in_item.node_id != '0) && (32'(in_item.node_id) < MAX_NODES);
  assign par_ok  = 32'(in_item.parent_id) < MAX_NODES;
  assign cnt_sat = (32'(in_item.jump_count) >> LOG_LEVELS) != 32'd0;

  // current climb position, taken from the read port when a step was issued
  assign q_cur = q_pend_r ? (built_r ? rda_q : '0) : q_cur_r;

  // parent memory
  always_ff @(posedge clk) begin
    if (p_we) begin
      pmem[p_wa] <= p_wd;
    end
    prd_q <= pmem[p_ra];
  end

  // jump memory, one write and two read ports
  always_ff @(posedge clk) begin
    if (j_we) begin
      jmem[j_wa] <= j_wd;
    end
    rda_q <= jmem[j_ra];
    rdb_q <= jmem[j_rb];
  end

  // memory addressing
  always_comb begin
    p_we = 1'b0;
    p_wa = bn_r;
    p_wd = '0;
    p_ra = bn_r;
    if (state_r == ST_CLEAR) begin
      p_we = 1'b1;
    end else if (accept && (in_item.mode == MODE_LOAD) && node_ok) begin
      p_we = 1'b1;
      p_wa = NB'(in_item.node_id);
      p_wd = par_ok ? in_item.parent_id : '0;
    end

    if (state_r == ST_QUERY) begin
      j_ra = {q_lvl_r[LBI-1:0], NB'(q_cur)};
    end else begin
      j_ra = {LBI'(bl_r - LBI'(1)), bn_r};
    end
    j_rb = {LBI'(s1_lvl_r - LBI'(1)), NB'(rda_q)};

    // level zero copies the parent entry, higher levels write from stage 2
    j_we = 1'b0;
    j_wa = {s2_lvl_r, s2_node_r};
    j_wd = rdb_q;
    if (s1_vld_r && (s1_lvl_r == '0)) begin
      j_we = 1'b1;
      j_wa = {s1_lvl_r, s1_node_r};
      j_wd = prd_q;
    end else if (s2_vld_r) begin
      j_we = 1'b1;
    end
  end

  // controller next state
  always_comb begin
    state_nxt     = state_r;
    bn_nxt        = bn_r;
    bl_nxt        = bl_r;
    built_nxt     = built_r;
    q_lvl_nxt     = q_lvl_r;
    q_cur_nxt     = q_cur_r;
    q_pend_nxt    = q_pend_r;
    q_cnt_nxt     = q_cnt_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = '0;
    s1_vld_nxt    = (state_r == ST_BUILD);
    s2_vld_nxt    = s1_vld_r && (s1_lvl_r != '0);

    unique case (state_r)
      ST_CLEAR: begin
        bn_nxt = bn_r + NB'(1);
        if (bn_r == NB'(MAX_NODES - 1)) begin
          bn_nxt    = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          out_valid_nxt = 1'b1;
          case (in_item.mode)
            MODE_BUILD: begin
              out_valid_nxt = 1'b0;
              bn_nxt        = '0;
              bl_nxt        = '0;
              state_nxt     = ST_BUILD;
            end
            MODE_QUERY: begin
              if (node_ok && !cnt_sat) begin
                out_valid_nxt = 1'b0;
                q_lvl_nxt     = '0;
                q_cur_nxt     = in_item.node_id;
                q_pend_nxt    = 1'b0;
                q_cnt_nxt     = in_item.jump_count;
                state_nxt     = ST_QUERY;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_BUILD: begin
        bn_nxt = bn_r + NB'(1);
        if (bn_r == NB'(MAX_NODES - 1)) begin
          bn_nxt    = '0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // wait until the last writes of this level have landed
        if (!s1_vld_r && !s2_vld_r) begin
          if (bl_r == LBI'(LOG_LEVELS - 1)) begin
            built_nxt     = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            bl_nxt    = bl_r + LBI'(1);
            state_nxt = ST_BUILD;
          end
        end
      end
      ST_QUERY: begin
        if (q_lvl_r == LB'(LOG_LEVELS)) begin
          out_valid_nxt            = 1'b1;
          out_item_nxt.ancestor_id = q_cur;
          out_item_nxt.found       = (q_cur != '0);
          q_pend_nxt               = 1'b0;
          state_nxt                = ST_IDLE;
        end else begin
          q_pend_nxt = q_cnt_r[0] && (q_cur != '0);
          q_cur_nxt  = q_cur;
          q_cnt_nxt  = q_cnt_r >> 1;
          q_lvl_nxt  = q_lvl_r + LB'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      bn_r        <= '0;
      bl_r        <= '0;
      built_r     <= 1'b0;
      q_pend_r    <= 1'b0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bn_r        <= bn_nxt;
      bl_r        <= bl_nxt;
      built_r     <= built_nxt;
      q_pend_r    <= q_pend_nxt;
      s1_vld_r    <= s1_vld_nxt;
      s2_vld_r    <= s2_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    s1_lvl_r   <= bl_r;
    s1_node_r  <= bn_r;
    s2_lvl_r   <= s1_lvl_r;
    s2_node_r  <= s1_node_r;
    q_lvl_r    <= q_lvl_nxt;
    q_cur_r    <= q_cur_nxt;
    q_cnt_r    <= q_cnt_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // a build never finishes in the cycle after its transfer
  a_build_not_immediate: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.mode == MODE_BUILD)) |=> !out_valid)
    else $error("build result too early");

  // a load is answered in the next cycle with nothing found
  a_load_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.mode == MODE_LOAD)) |=> (out_valid && !out_item.found))
    else $error("load result missing");

  // found flag agrees with the ancestor field
  a_found_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.found == (out_item.ancestor_id != '0)))
    else $error("found flag inconsistent");

  // the two build write sources never collide
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_vld_r && (s1_lvl_r == '0) && s2_vld_r))
    else $error("jump memory write collision");

endmodule
